// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cpd_pkg.sv =====
// Types and constants of the charger presence debouncer.
// Used by the top level and its checker; depends on nothing.
package cpd_pkg;

  localparam int CURRENT_BITS = 24;
  localparam int ELAPSED_BITS = 16;
  localparam int THR_BITS     = 23;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_INDEX_BITS = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IDLE_DEADBAND   = 3'd0,
    CFG_ENTER_THRESHOLD = 3'd1,
    CFG_EXIT_THRESHOLD  = 3'd2,
    CFG_NEG_CHARGING    = 3'd3,
    CFG_DEBOUNCE_TIME   = 3'd4,
    CFG_HOLD_TIME       = 3'd5
  } cfg_index_t;

  // Reset values of the registers
  localparam logic [THR_BITS-1:0]      RST_IDLE_DEADBAND   = 23'd50;
  localparam logic [THR_BITS-1:0]      RST_ENTER_THRESHOLD = 23'd200;
  localparam logic [THR_BITS-1:0]      RST_EXIT_THRESHOLD  = 23'd100;
  localparam logic                     RST_NEG_CHARGING    = 1'b0;
  localparam logic [CFG_DATA_BITS-1:0] RST_DEBOUNCE_TIME   = 24'd500;
  localparam logic [CFG_DATA_BITS-1:0] RST_HOLD_TIME       = 24'd2000;

  typedef struct packed {
    logic signed [CURRENT_BITS-1:0] current_ma;
    logic [ELAPSED_BITS-1:0]        elapsed_ms;
  } cpd_in_t;

  typedef struct packed {
    logic charger_present;
    logic changed;
  } cpd_out_t;

endpackage

// ===== src/charger_presence_debouncer.sv =====
// Charger presence debouncer: top level.
// Depends on cpd_pkg for the payload types, register indexes and reset values.
//
// Turns a stream of signed pack current samples, each with the milliseconds
// elapsed since the previous one, into a debounced charger presence flag.
// Every accepted sample yields exactly one result transaction carrying the
// flag after that sample and a changed bit that is set when this sample
// flipped it. The block takes one sample per clock cycle while the result
// is not stalled; a sample passes through the input register and then the
// result register, and its result is on the result port once the result
// register holds it. The one-per-cycle rate is set by the state update loop:
// the since-flip add, the active timer's saturating add and the debounce
// and hold compares are combinational, so the next sample always sees the
// state the previous one left. A stalled result holds the block, and the
// stall reaches the input side once the input register is also full.
// Currents at or below the idle deadband in magnitude count as idle. While
// absent, a charging current of at least the enter threshold runs the enter
// timer; while present, a current below the exit threshold (or idle) runs
// the exit timer. The flag flips when the running timer reaches the
// debounce time and the hold time after the last flip (or after reset) has
// passed. Timers saturate at 2^TIMER_BITS - 1, so a hold time beyond that
// blocks every flip. Configuration writes are always taken (ready is tied
// high) and must only be issued while no sample is in flight; writes to
// unknown indexes are dropped.
module charger_presence_debouncer
  import cpd_pkg::*;
#(
  parameter int TIMER_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  // sample channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  cpd_in_t                   in_data,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output cpd_out_t                  out_data,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Width that holds both a timer and a 24-bit time register
  localparam int CMP_BITS = (TIMER_BITS > CFG_DATA_BITS) ? TIMER_BITS : CFG_DATA_BITS;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // Configuration registers
  logic [THR_BITS-1:0]      deadband_limit_ma;
  logic [THR_BITS-1:0]      enter_threshold_ma;
  logic [THR_BITS-1:0]      exit_threshold_ma;
  logic                     negative_is_charging;
  logic [CFG_DATA_BITS-1:0] debounce_time_ms;
  logic [CFG_DATA_BITS-1:0] hold_time_ms;

  // Filter state
  logic                  present_flag;
  logic                  enter_timing;
  logic [TIMER_BITS-1:0] enter_elapsed;
  logic                  exit_timing;
  logic [TIMER_BITS-1:0] exit_elapsed;
  logic [TIMER_BITS-1:0] since_flip;

  // Input register
  logic    in_full;
  cpd_in_t in_item;

  // Handshake control
  logic advance;
  logic fire;

  // Per-sample datapath
  logic [CURRENT_BITS-1:0]        cur_u;
  logic [CURRENT_BITS-1:0]        cur_mag;
  logic signed [CURRENT_BITS:0]   cur_ext;
  logic signed [CURRENT_BITS:0]   enter_pos;
  logic signed [CURRENT_BITS:0]   enter_neg;
  logic signed [CURRENT_BITS:0]   exit_pos;
  logic signed [CURRENT_BITS:0]   exit_neg;
  logic                           idle;
  logic                           want_enter;
  logic                           want_exit;
  logic [TIMER_BITS-1:0]          dt;
  logic [TIMER_BITS:0]            since_sum;
  logic [TIMER_BITS-1:0]          since_next;
  logic                           hold;
  logic                           cond;
  logic                           act_timing;
  logic [TIMER_BITS-1:0]          act_elapsed;
  logic [TIMER_BITS:0]            act_sum;
  logic [TIMER_BITS-1:0]          act_next;
  logic                           flip;

  // Configuration port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_limit_ma    <= RST_IDLE_DEADBAND;
      enter_threshold_ma   <= RST_ENTER_THRESHOLD;
      exit_threshold_ma    <= RST_EXIT_THRESHOLD;
      negative_is_charging <= RST_NEG_CHARGING;
      debounce_time_ms     <= RST_DEBOUNCE_TIME;
      hold_time_ms         <= RST_HOLD_TIME;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDLE_DEADBAND:   deadband_limit_ma    <= cfg_data[THR_BITS-1:0];
        CFG_ENTER_THRESHOLD: enter_threshold_ma   <= cfg_data[THR_BITS-1:0];
        CFG_EXIT_THRESHOLD:  exit_threshold_ma    <= cfg_data[THR_BITS-1:0];
        CFG_NEG_CHARGING:    negative_is_charging <= cfg_data[0];
        CFG_DEBOUNCE_TIME:   debounce_time_ms     <= cfg_data;
        CFG_HOLD_TIME:       hold_time_ms         <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Advance the sample out of the input register whenever the result
  // register is empty or is being drained this cycle.
  assign advance  = !out_valid || !out_stall;
  assign fire     = in_full && advance;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item <= in_data;
    end
  end

  // Classify the current: magnitude for the deadband, signed compares
  // against the thresholds with the charging polarity applied.
  always_comb begin
    cur_u     = in_item.current_ma;
    cur_mag   = cur_u[CURRENT_BITS-1] ? (~cur_u + 1'b1) : cur_u;
    cur_ext   = {in_item.current_ma[CURRENT_BITS-1], in_item.current_ma};
    enter_pos = signed'((CURRENT_BITS + 1)'(enter_threshold_ma));
    exit_pos  = signed'((CURRENT_BITS + 1)'(exit_threshold_ma));
    enter_neg = -enter_pos;
    exit_neg  = -exit_pos;
    idle      = cur_mag <= CURRENT_BITS'(deadband_limit_ma);
    if (negative_is_charging) begin
      want_enter = !idle && (cur_ext <= enter_neg);
      want_exit  = idle || (cur_ext > exit_neg);
    end else begin
      want_enter = !idle && (cur_ext >= enter_pos);
      want_exit  = idle || (cur_ext < exit_pos);
    end
  end

  // Advance the timers, check hold and debounce, decide the flip.
  always_comb begin
    dt         = TIMER_BITS'(in_item.elapsed_ms);
    since_sum  = {1'b0, since_flip} + {1'b0, dt};
    since_next = since_sum[TIMER_BITS] ? TIMER_MAX : since_sum[TIMER_BITS-1:0];
    hold       = CMP_BITS'(since_next) < CMP_BITS'(hold_time_ms);

    cond        = present_flag ? want_exit : want_enter;
    act_timing  = present_flag ? exit_timing : enter_timing;
    act_elapsed = present_flag ? exit_elapsed : enter_elapsed;
    act_sum     = {1'b0, act_elapsed} + {1'b0, dt};
    if (!cond || !act_timing) begin
      act_next = '0;  // start fresh, or drop a broken condition
    end else begin
      act_next = act_sum[TIMER_BITS] ? TIMER_MAX : act_sum[TIMER_BITS-1:0];
    end
    flip = cond && !hold && (CMP_BITS'(act_next) >= CMP_BITS'(debounce_time_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_flag  <= 1'b0;
      enter_timing  <= 1'b0;
      enter_elapsed <= '0;
      exit_timing   <= 1'b0;
      exit_elapsed  <= '0;
      since_flip    <= '0;
    end else if (fire) begin
      present_flag <= present_flag ^ flip;
      since_flip   <= flip ? '0 : since_next;
      if (!present_flag) begin
        enter_timing  <= cond;
        enter_elapsed <= act_next;
        if (flip) begin
          exit_timing  <= 1'b0;
          exit_elapsed <= '0;
        end
      end else begin
        exit_timing  <= cond;
        exit_elapsed <= act_next;
        if (flip) begin
          enter_timing  <= 1'b0;
          enter_elapsed <= '0;
        end
      end
    end
  end

  // Result register: load on fire, drop once the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.charger_present <= present_flag ^ flip;
      out_data.changed         <= flip;
    end
  end

endmodule

// ===== src/cpd_checker.sv =====
// Port-level checker for the charger presence debouncer, with its bind.
// Depends on cpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpd_checker
  import cpd_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_stall,
  input cpd_out_t out_data
);

  // Flag carried by the last delivered result; absent after reset
  logic last_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_present <= 1'b0;
    end else if (out_valid && !out_stall) begin
      last_present <= out_data.charger_present;
    end
  end

  `ASSERT_CLK(a_stall_holds, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "result pending after reset")
  `ASSERT_CLK(a_changed_matches, clk, rst, out_valid |-> (out_data.changed == (out_data.charger_present != last_present)), "changed bit disagrees with flag history")

endmodule

bind charger_presence_debouncer cpd_checker u_cpd_checker (.*);

// ===== verif/charger_presence_debouncer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the charger presence debouncer, driven on all three channels.
// Depends on cpd_pkg and charger_presence_debouncer; nothing else is read.
module charger_presence_debouncer_tb;
  import cpd_pkg::*;

  localparam int TIMER_BITS      = 24;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int SATURATE_ITEMS  = 280;
  localparam int RESULT_LATENCY  = 2;
  localparam int CYCLE_LIMIT     = 200_000;
  localparam int REPORT_LIMIT    = 10;

  // Indexes that decode to no register; writes to them must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // Current patterns the random stimulus keeps up for a run of samples
  typedef enum logic [1:0] {DRIVE_CHARGE, DRIVE_DROP, DRIVE_EDGE} drive_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    cpd_in_t                   sample;
    logic                      typed;
    cpd_out_t                  result;
  } plan_row_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  cpd_in_t                   in_data;
  logic                      out_valid;
  logic                      out_stall;
  cpd_out_t                  out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  charger_presence_debouncer #(
    .TIMER_BITS(TIMER_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Register copies held by the predictor
  logic [THR_BITS-1:0]   deadband_ma;
  logic [THR_BITS-1:0]   enter_ma;
  logic [THR_BITS-1:0]   exit_ma;
  logic                  neg_charging;
  logic [TIMER_BITS-1:0] settle_ms;
  logic [TIMER_BITS-1:0] hold_ms;

  // Filter state held by the predictor
  logic                  present;
  logic                  enter_run;
  logic                  exit_run;
  logic [TIMER_BITS-1:0] enter_acc_ms;
  logic [TIMER_BITS-1:0] exit_acc_ms;
  logic [TIMER_BITS-1:0] since_flip_ms;

  // Expected presence results, oldest first
  cpd_out_t presence_q[$];

  int gap_pct   = 16;
  int stall_pct = 71;
  int mismatch_count;
  int flip_count;
  int samples_sent;
  int reg_writes;
  int cycle_count;

  drive_t drive_mode;
  int     drive_left;

  // Add elapsed time to a timer, pinning it at the all-ones maximum
  function automatic logic [TIMER_BITS-1:0] timer_sum(logic [TIMER_BITS-1:0] acc,
                                                      logic [ELAPSED_BITS-1:0] dt);
    logic [TIMER_BITS:0] total;
    total = {1'b0, acc} + dt;
    return total[TIMER_BITS] ? '1 : total[TIMER_BITS-1:0];
  endfunction

  // Start the timer on the first sample of its condition, advance it after that,
  // clear it as soon as the condition fails
  function automatic void advance_timer(input logic cond, inout logic running,
                                        inout logic [TIMER_BITS-1:0] acc,
                                        input logic [ELAPSED_BITS-1:0] dt);
    if (!cond) begin
      running = 1'b0;
      acc     = '0;
    end else if (running) begin
      acc = timer_sum(acc, dt);
    end else begin
      running = 1'b1;
      acc     = '0;
    end
  endfunction

  // Apply one sample to the predictor state and return the presence it leaves
  function automatic cpd_out_t predict_presence(cpd_in_t s);
    logic signed [CURRENT_BITS:0] cur;
    logic signed [CURRENT_BITS:0] mag;
    logic signed [CURRENT_BITS:0] dead;
    logic signed [CURRENT_BITS:0] thr_in;
    logic signed [CURRENT_BITS:0] thr_out;
    logic quiet;
    logic cond;
    logic hold;
    logic flip;
    cpd_out_t r;
    // one extra bit keeps the magnitude of the most negative current exact
    cur     = s.current_ma;
    mag     = (cur < 0) ? -cur : cur;
    dead    = $signed({2'b00, deadband_ma});
    thr_in  = $signed({2'b00, enter_ma});
    thr_out = $signed({2'b00, exit_ma});
    quiet   = mag <= dead;
    flip    = 1'b0;
    since_flip_ms = timer_sum(since_flip_ms, s.elapsed_ms);
    hold    = since_flip_ms < hold_ms;
    if (!present) begin
      cond = !quiet && (neg_charging ? (cur <= -thr_in) : (cur >= thr_in));
      advance_timer(cond, enter_run, enter_acc_ms, s.elapsed_ms);
      if (cond && !hold && enter_acc_ms >= settle_ms) begin
        present     = 1'b1;
        flip        = 1'b1;
        exit_run    = 1'b0;
        exit_acc_ms = '0;
      end
    end else begin
      cond = quiet || (neg_charging ? (cur > -thr_out) : (cur < thr_out));
      advance_timer(cond, exit_run, exit_acc_ms, s.elapsed_ms);
      if (cond && !hold && exit_acc_ms >= settle_ms) begin
        present      = 1'b0;
        flip         = 1'b1;
        enter_run    = 1'b0;
        enter_acc_ms = '0;
      end
    end
    if (flip) begin
      since_flip_ms = '0;
    end
    r.charger_present = present;
    r.changed         = flip;
    return r;
  endfunction

  function automatic plan_row_t sample_row(int cur, int ms);
    plan_row_t r;
    r = '0;
    r.kind              = ROW_SAMPLE;
    r.sample.current_ma = cur[CURRENT_BITS-1:0];
    r.sample.elapsed_ms = ms[ELAPSED_BITS-1:0];
    return r;
  endfunction

  function automatic plan_row_t checked_row(int cur, int ms, logic now_present, logic flipped);
    plan_row_t r;
    r = sample_row(cur, ms);
    r.typed                  = 1'b1;
    r.result.charger_present = now_present;
    r.result.changed         = flipped;
    return r;
  endfunction

  function automatic plan_row_t write_row(logic [CFG_INDEX_BITS-1:0] idx,
                                          logic [CFG_DATA_BITS-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.data  = val;
    return r;
  endfunction

  // Mostly a typical range, now and then one of the two extremes
  function automatic logic [CFG_DATA_BITS-1:0] pick_setting(int lo, int hi,
                                                           logic [CFG_DATA_BITS-1:0] top);
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return '0;
    end else if (pick < 16) begin
      return top;
    end
    return CFG_DATA_BITS'($urandom_range(hi, lo));
  endfunction

  // Build runs of charging or dropping current with random content; sprinkle in
  // threshold edges and raw noise so the debounce is broken now and then
  function automatic cpd_in_t random_sample();
    cpd_in_t s;
    int pick;
    int mag;
    int lim;
    if (drive_left == 0) begin
      pick       = $urandom_range(99);
      drive_mode = (pick < 45) ? DRIVE_CHARGE : (pick < 90) ? DRIVE_DROP : DRIVE_EDGE;
      drive_left = $urandom_range(24, 2);
    end
    drive_left--;
    pick = $urandom_range(99);
    if (pick < 12) begin
      s.current_ma = CURRENT_BITS'($urandom);
    end else if (pick < 15) begin
      s.current_ma = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    end else begin
      case (drive_mode)
        DRIVE_CHARGE: begin
          mag          = enter_ma + $urandom_range(2000);
          s.current_ma = CURRENT_BITS'(neg_charging ? -mag : mag);
        end
        DRIVE_DROP: begin
          mag          = $urandom_range(exit_ma + 20);
          s.current_ma = CURRENT_BITS'($urandom_range(1) ? -mag : mag);
        end
        default: begin
          pick         = $urandom_range(2);
          mag          = (pick == 0) ? deadband_ma : (pick == 1) ? enter_ma : exit_ma;
          mag          = mag + $urandom_range(4) - 2;
          s.current_ma = CURRENT_BITS'($urandom_range(1) ? -mag : mag);
        end
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      s.elapsed_ms = '0;
    end else if (pick < 15) begin
      s.elapsed_ms = '1;
    end else if (pick < 25) begin
      s.elapsed_ms = ELAPSED_BITS'($urandom);
    end else begin
      // keep steps well under the debounce time so timers build up over a run
      lim = settle_ms / 3 + 50;
      if (lim > 65535) begin
        lim = 65535;
      end
      s.elapsed_ms = ELAPSED_BITS'($urandom_range(lim));
    end
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Offer one sample, hold it until the transaction completes, then predict
  task automatic send_sample(cpd_in_t s, logic typed = 1'b0, cpd_out_t typed_result = '0);
    cpd_out_t predicted;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    predicted = predict_presence(s);
    presence_q.push_back(typed ? typed_result : predicted);
    samples_sent++;
  endtask

  // Drop the sample valid and wait until every expected result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (presence_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDLE_DEADBAND:   deadband_ma  = val[THR_BITS-1:0];
      CFG_ENTER_THRESHOLD: enter_ma     = val[THR_BITS-1:0];
      CFG_EXIT_THRESHOLD:  exit_ma      = val[THR_BITS-1:0];
      CFG_NEG_CHARGING:    neg_charging = val[0];
      CFG_DEBOUNCE_TIME:   settle_ms    = val;
      CFG_HOLD_TIME:       hold_ms      = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Reprogram every register between phases; random top bits exercise the
  // masking of the narrower threshold registers
  task automatic program_random_setting();
    logic [CFG_DATA_BITS-1:0] val;
    wait_drained();
    val = pick_setting(0, 120, 24'h7FFFFF);
    write_reg(CFG_IDLE_DEADBAND, {1'($urandom_range(1)), val[THR_BITS-1:0]});
    val = pick_setting(100, 1500, 24'h7FFFFF);
    write_reg(CFG_ENTER_THRESHOLD, {1'($urandom_range(1)), val[THR_BITS-1:0]});
    val = pick_setting(50, 1500, 24'h7FFFFF);
    write_reg(CFG_EXIT_THRESHOLD, {1'($urandom_range(1)), val[THR_BITS-1:0]});
    write_reg(CFG_NEG_CHARGING, CFG_DATA_BITS'($urandom));
    write_reg(CFG_DEBOUNCE_TIME, pick_setting(0, 3000, '1));
    write_reg(CFG_HOLD_TIME, pick_setting(0, 5000, '1));
  endtask

  // Receiver: stall at the rate of the current phase, never during reset
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Compare every result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    cpd_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (presence_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: present=%0b changed=%0b",
                                  out_data.charger_present, out_data.changed));
      end else begin
        want = presence_q.pop_front();
        if (out_data.charger_present !== want.charger_present) begin
          report_mismatch($sformatf("charger_present: expected %0b, got %0b",
                                    want.charger_present, out_data.charger_present));
        end
        if (out_data.changed !== want.changed) begin
          report_mismatch($sformatf("changed: expected %0b, got %0b",
                                    want.changed, out_data.changed));
        end
      end
      if (out_data.changed === 1'b1) begin
        flip_count++;
      end
    end
  end

  // Bound the run so a hung handshake cannot stall the simulation forever
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    cpd_in_t   stim;

    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst       <= 1'b1;

    deadband_ma   = RST_IDLE_DEADBAND;
    enter_ma      = RST_ENTER_THRESHOLD;
    exit_ma       = RST_EXIT_THRESHOLD;
    neg_charging  = RST_NEG_CHARGING;
    settle_ms     = RST_DEBOUNCE_TIME;
    hold_ms       = RST_HOLD_TIME;
    present       = 1'b0;
    enter_run     = 1'b0;
    exit_run      = 1'b0;
    enter_acc_ms  = '0;
    exit_acc_ms   = '0;
    since_flip_ms = '0;
    drive_mode    = DRIVE_CHARGE;
    drive_left    = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed walk. Reset settings first: hold runs from reset, the first
    // charging sample only starts the timer, a full debounce later it flips.
    plan = '{
      checked_row(0, 0, 1'b0, 1'b0),
      checked_row(8388607, 65535, 1'b0, 1'b0),
      checked_row(8388607, 500, 1'b1, 1'b1),
      checked_row(-8388608, 65535, 1'b1, 1'b0),
      sample_row(100, 300),            // at the exit threshold: exit timer clears
      sample_row(99, 400),
      sample_row(-50, 600),            // at the deadband: idle, exit completes
      sample_row(-51, 65535),
      sample_row(200, 0),
      sample_row(199, 700),
      // swap polarity and drop the debounce to zero
      write_row(CFG_NEG_CHARGING, 24'd1),
      write_row(CFG_DEBOUNCE_TIME, 24'd0),
      sample_row(-200, 0),
      sample_row(-8388608, 1999),      // inside the hold window
      sample_row(-100, 0),
      sample_row(-99, 1),              // hold ends exactly here
      sample_row(8388607, 65535),
      // debounce and hold at their maximum: nothing may flip yet
      write_row(CFG_DEBOUNCE_TIME, 24'hFFFFFF),
      write_row(CFG_HOLD_TIME, 24'hFFFFFF),
      sample_row(-8388608, 65535),
      sample_row(-8388608, 65535),
      sample_row(-8388608, 65535),
      // widest deadband: only the most negative current escapes it
      write_row(CFG_IDLE_DEADBAND, 24'h7FFFFF),
      write_row(CFG_ENTER_THRESHOLD, 24'h7FFFFF),
      write_row(CFG_EXIT_THRESHOLD, 24'd0),
      write_row(CFG_DEBOUNCE_TIME, 24'd0),
      write_row(CFG_HOLD_TIME, 24'd0),
      checked_row(-8388608, 0, 1'b1, 1'b1),
      checked_row(8388607, 0, 1'b0, 1'b1),
      sample_row(-8388607, 0),
      // writes to undecoded indexes must leave every register alone
      write_row(CFG_SPARE_LO, 24'hFFFFFF),
      write_row(CFG_SPARE_HI, 24'hFFFFFF),
      sample_row(0, 1)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_sample(plan[i].sample, plan[i].typed, plan[i].result);
      end
    end

    // Random phases: sparse sender gaps with a heavily stalled receiver, then
    // the reverse, then both sides at full rate. Each phase drains completely
    // before its register writes.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES / 3) begin
        gap_pct   = 71;
        stall_pct = 16;
      end else if (phase == 2 * RANDOM_PHASES / 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      program_random_setting();
      repeat (ITEMS_PER_PHASE) send_sample(random_sample());
    end

    // Saturation run: force the flag clear with a zero debounce, then hold a
    // charging current with maximum steps until both the enter timer and the
    // since-flip counter pin at the top and the flag finally sets.
    wait_drained();
    write_reg(CFG_IDLE_DEADBAND, CFG_DATA_BITS'(RST_IDLE_DEADBAND));
    write_reg(CFG_ENTER_THRESHOLD, CFG_DATA_BITS'(RST_ENTER_THRESHOLD));
    write_reg(CFG_EXIT_THRESHOLD, CFG_DATA_BITS'(RST_EXIT_THRESHOLD));
    write_reg(CFG_NEG_CHARGING, CFG_DATA_BITS'(RST_NEG_CHARGING));
    write_reg(CFG_DEBOUNCE_TIME, 24'd0);
    write_reg(CFG_HOLD_TIME, 24'd0);
    stim = '0;
    send_sample(stim);
    wait_drained();
    write_reg(CFG_DEBOUNCE_TIME, '1);
    write_reg(CFG_HOLD_TIME, '1);
    repeat (SATURATE_ITEMS) begin
      stim.current_ma = CURRENT_BITS'($urandom_range(8388607, RST_ENTER_THRESHOLD));
      stim.elapsed_ms = '1;
      send_sample(stim);
    end

    wait_drained();
    cfg_valid <= 1'b0;
    // allow a stray extra result to surface before judging
    repeat (RESULT_LATENCY + 2) @(posedge clk);

    $display("Ran %0d samples and %0d register writes; %0d presence flips seen.",
             samples_sent, reg_writes, flip_count);
    $display("Covered both polarities, hold and debounce extremes, saturating timers.");
    if (mismatch_count == 0 && presence_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/cpd_pkg.sv
src/charger_presence_debouncer.sv
src/cpd_checker.sv
verif/charger_presence_debouncer_tb.sv
